/* src/fpat_pkg.sv */
// ----------------------------------------------------------------------------
// fpat_pkg
// Shared types, request codes and sizes for the fault persistence alarm table.
// ----------------------------------------------------------------------------
package fpat_pkg;

  localparam int DEFAULT_ENTRIES = 32;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  // request codes as they arrive
  localparam logic [2:0] REQ_BEGIN  = 3'd0;
  localparam logic [2:0] REQ_REPORT = 3'd1;
  localparam logic [2:0] REQ_SWEEP  = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_LIST   = 3'd4;

  // classified operations handed to the back end
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_BEGIN  = 3'd1;
  localparam logic [2:0] OP_REPORT = 3'd2;
  localparam logic [2:0] OP_SWEEP  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;
  localparam logic [2:0] OP_LIST   = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] frame_number;
    logic [31:0] point_tag;
    logic [15:0] alarm_after;
  } in_word_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] out_tag;
    logic [31:0] first_bad_frame;
    logic [31:0] last_bad_frame;
    logic [31:0] bad_frame_count;
    logic        alarm_flag;
    logic        table_full;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] frame;
    logic [31:0] tag;
    logic [15:0] thr;
  } cmd_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] count;
    logic [15:0] thr;
  } rec_t;

  // result word carrying one table record
  function automatic out_word_t slot_word(rec_t r);
    out_word_t w;
    w.record_valid    = 1'b1;
    w.out_tag         = r.tag;
    w.first_bad_frame = r.first;
    w.last_bad_frame  = r.last;
    w.bad_frame_count = r.count;
    w.alarm_flag      = (r.count >= {16'd0, r.thr});
    w.table_full      = 1'b0;
    w.last_result     = 1'b0;
    return w;
  endfunction

  // result word with no record
  function automatic out_word_t empty_word(logic [31:0] tag, logic full_flag);
    out_word_t w;
    w                 = '0;
    w.out_tag         = tag;
    w.table_full      = full_flag;
    w.last_result     = 1'b1;
    return w;
  endfunction

endpackage

/* src/fault_persistence_alarm_table_unit.sv */
// ----------------------------------------------------------------------------
// fault_persistence_alarm_table_unit
// Fault record table keyed by monitor point tag, with frame sweep and alarms.
// ----------------------------------------------------------------------------
// Request words enter a two-word command queue and are carried out one at a
// time by the table engine; results leave through a two-word result queue.
// Begin frame and unknown requests go straight to the result step; fault
// reports and queries pass a parallel tag compare, a lowest-slot pick with a
// record memory read, and, for reports, a write-back; sweep and list scans
// read each table entry in turn from the record memory before checking it.
// A stalled result queue holds the engine. No clearing pass follows reset.
module fault_persistence_alarm_table_unit #(
  parameter int TABLE_ENTRIES = fpat_pkg::DEFAULT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fpat_pkg::in_word_t  din,
  output logic                full,
  input  logic                pop,
  output fpat_pkg::out_word_t dout,
  output logic                empty
);
  import fpat_pkg::*;

  cmd_t      cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_push;
  out_word_t res_word;
  logic      res_full;

  // request intake
  fpat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (din),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // table engine
  fpat_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  // result queue
  fpat_fifo #(.word_t(out_word_t)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (pop),
    .dout  (dout),
    .empty (empty)
  );

endmodule

/* src/fpat_fifo.sv */
// ----------------------------------------------------------------------------
// fpat_fifo
// Two-entry queue of words, used between the parts of the table unit.
// ----------------------------------------------------------------------------
module fpat_fifo #(
  parameter type word_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t din,
  output logic  full,
  input  logic  pop,
  output word_t dout,
  output logic  empty
);

  word_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

endmodule

/* src/fpat_front.sv */
// ----------------------------------------------------------------------------
// fpat_front
// Accepts request words, classifies the request code and queues commands.
// ----------------------------------------------------------------------------
module fpat_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fpat_pkg::in_word_t din,
  output logic              full,
  input  logic              cmd_pop,
  output fpat_pkg::cmd_t    cmd,
  output logic              cmd_empty
);
  import fpat_pkg::*;

  cmd_t cls;

  // map request code to operation, unknown codes become no-ops
  always_comb begin
    cls.frame = din.frame_number;
    cls.tag   = din.point_tag;
    cls.thr   = din.alarm_after;
    unique case (din.req_type)
      REQ_BEGIN:  cls.op = OP_BEGIN;
      REQ_REPORT: cls.op = OP_REPORT;
      REQ_SWEEP:  cls.op = OP_SWEEP;
      REQ_QUERY:  cls.op = OP_QUERY;
      REQ_LIST:   cls.op = OP_LIST;
      default:    cls.op = OP_NOP;
    endcase
  end

  fpat_fifo #(.word_t(cmd_t)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

endmodule

/* src/fpat_back.sv */
// ----------------------------------------------------------------------------
// fpat_back
// Table engine: tag match, insert and update, sweep and list scans.
// ----------------------------------------------------------------------------
module fpat_back #(
  parameter int TABLE_ENTRIES = fpat_pkg::DEFAULT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  fpat_pkg::cmd_t      cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                res_push,
  output fpat_pkg::out_word_t res_word,
  input  logic                res_full
);
  import fpat_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SCHK  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]               state;
  cmd_t                     cur;
  logic [31:0]              frame_now;
  logic [TABLE_ENTRIES-1:0] used;
  logic [TABLE_ENTRIES-1:0] seen;
  logic [31:0]              tags [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] free;
  logic [IDX_W-1:0]         idx;
  logic [RES_CNT_W-1:0]     n_out;
  logic                     held_v;
  out_word_t                res;

  rec_t             mem [TABLE_ENTRIES];
  rec_t             rd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  rec_t             mem_wd;
  logic [IDX_W-1:0] mem_ra;

  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             any_hit;
  logic             any_free;
  logic             scan_take;
  logic             scan_emit;
  logic             scan_stall;
  rec_t             upd;

  // lowest matching and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = IDX_W'(i);
      if (free[i]) free_idx = IDX_W'(i);
    end
    any_hit  = |hit;
    any_free = |free;
  end

  // record memory, registered read
  assign mem_ra = (state == S_PICK) ? hit_idx : idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[mem_ra];
  end

  // updated record for a repeat report
  always_comb begin
    upd      = rd;
    upd.last = frame_now;
    if (rd.count != 32'hFFFF_FFFF) upd.count = rd.count + 32'd1;
  end

  // memory write port
  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = idx;
    mem_wd       = upd;
    if (state == S_PICK && cur.op == OP_REPORT && !any_hit && any_free) begin
      mem_we       = 1'b1;
      mem_wa       = free_idx;
      mem_wd.tag   = cur.tag;
      mem_wd.first = frame_now;
      mem_wd.last  = frame_now;
      mem_wd.count = 32'd1;
      mem_wd.thr   = cur.thr;
    end else if (state == S_UPD && cur.op == OP_REPORT) begin
      mem_we = 1'b1;
    end
  end

  // scan decisions for the entry read this cycle
  always_comb begin
    if (cur.op == OP_SWEEP) begin
      scan_take = used[idx] && !seen[idx];
    end else begin
      scan_take = used[idx];
    end
    scan_emit  = scan_take && (rd.count >= {16'd0, rd.thr}) &&
                 (n_out < RES_CNT_W'(MAX_RESULTS));
    scan_stall = scan_emit && held_v && res_full;
  end

  // result queue push
  always_comb begin
    res_push = 1'b0;
    res_word = res;
    if (state == S_SCHK && scan_emit && held_v && !res_full) begin
      res_push             = 1'b1;
      res_word.last_result = 1'b0;
    end else if (state == S_EMIT && !res_full) begin
      res_push             = 1'b1;
      res_word.last_result = 1'b1;
    end
  end

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;

  // tag registers
  always_ff @(posedge clk) begin
    if (state == S_PICK && cur.op == OP_REPORT && !any_hit && any_free) begin
      tags[free_idx] <= cur.tag;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frame_now <= '0;
      used      <= '0;
      seen      <= '0;
      held_v    <= 1'b0;
      n_out     <= '0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            cur    <= cmd;
            held_v <= 1'b0;
            n_out  <= '0;
            idx    <= '0;
            res    <= empty_word(32'd0, 1'b0);
            unique case (cmd.op)
              OP_BEGIN: begin
                frame_now <= cmd.frame;
                seen      <= '0;
                state     <= S_EMIT;
              end
              OP_REPORT, OP_QUERY: state <= S_MATCH;
              OP_SWEEP, OP_LIST:   state <= S_SCAN;
              default:             state <= S_EMIT;
            endcase
          end
        end
        S_MATCH: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i]  <= used[i] && (tags[i] == cur.tag);
            free[i] <= !used[i];
          end
          state <= S_PICK;
        end
        S_PICK: begin
          if (any_hit) begin
            idx   <= hit_idx;
            state <= S_UPD;
          end else if (cur.op == OP_REPORT && any_free) begin
            used[free_idx] <= 1'b1;
            seen[free_idx] <= 1'b1;
            res            <= slot_word('{tag: cur.tag, first: frame_now,
                                          last: frame_now, count: 32'd1,
                                          thr: cur.thr});
            state          <= S_EMIT;
          end else begin
            res   <= empty_word(cur.tag, cur.op == OP_REPORT);
            state <= S_EMIT;
          end
        end
        S_UPD: begin
          if (cur.op == OP_REPORT) begin
            seen[idx] <= 1'b1;
            res       <= slot_word(upd);
          end else begin
            res <= slot_word(rd);
          end
          state <= S_EMIT;
        end
        S_SCAN: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (!scan_stall) begin
            if (cur.op == OP_SWEEP && scan_take) used[idx] <= 1'b0;
            if (scan_emit) begin
              res    <= slot_word(rd);
              held_v <= 1'b1;
              n_out  <= n_out + RES_CNT_W'(1);
            end
            if (idx == LAST_IDX) begin
              state <= S_EMIT;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SCAN;
            end
          end
        end
        S_EMIT: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
